>>> rtl/m4inv_pkg.sv
// Package for the 4x4 matrix inverse: payload types, internal widths and sequencer codes.
package m4inv_pkg;

   // Widths of the shared datapath.
   localparam int ELEM_W     = 16;
   localparam int POS_W      = 4;
   localparam int VALUE_W    = 32;
   localparam int MINOR_W    = 33;
   localparam int COF_W      = 51;
   localparam int DET_W      = 70;
   localparam int MULB_W     = 34;
   localparam int PROD_W     = ELEM_W + MULB_W;
   localparam int CHUNK_W    = 26;
   localparam int FRAC_SHIFT = 24;
   localparam int NUM_W      = COF_W + FRAC_SHIFT;
   localparam int REM_W      = DET_W + 1;
   localparam int CNT_W      = 7;
   localparam int QUO_W      = VALUE_W - 1;
   localparam int SING_SHIFT = 8;

   localparam logic [VALUE_W-1:0] SAT_POS = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [POS_W-1:0]   LAST_POS = {POS_W{1'b1}};

   // One input transaction.
   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [POS_W-1:0]         position;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          out_position;
      logic                      singular;
      logic                      last;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COF,
      ST_COF_END,
      ST_DET,
      ST_DET_END,
      ST_DET_ABS,
      ST_DIV_LD,
      ST_DIV,
      ST_OUT
   } state_type;

   // What to do with the registered product in the following cycle.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_MSET,
      ACT_MSUB,
      ACT_CADD,
      ACT_CSUB,
      ACT_DLO,
      ACT_DHI
   } act_type;

   // Index i of a 3-entry list that leaves out the entry x of 0..3.
   function automatic logic [1:0] skip_index(input logic [1:0] i, input logic [1:0] x);
      logic [1:0] res;
      res = (i < x) ? i : i + 2'd1;
      return res;
   endfunction

endpackage

>>> rtl/matrix4_inverse_top.sv
// Top level of the 4x4 matrix inverse by adjugate and exact per-element division.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_data  (m4inv_pkg::req_type)
// rsp      out        rsp_valid/rsp_stall   rsp_data  (m4inv_pkg::rsp_type)
//
// A transaction at positions 0 to 14 only writes the element store and yields nothing.
// Position 15 starts a run on one shared 16x34 multiplier: 16 cofactors, the
// determinant, then per result a load state, restoring division and an output
// state; a singular matrix skips the division.
// Synchronous active-high reset clears the element store and the control state.
// req_stall is high for the whole run; rsp_stall holds the output register and
// pauses the sequencer in its output state.
module matrix4_inverse_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  m4inv_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output m4inv_pkg::rsp_type rsp_data
);

   // State and storage.
   m4inv_pkg::state_type state_ff, state_in;
   m4inv_pkg::act_type   act_ff, act_in;
   logic signed [m4inv_pkg::ELEM_W-1:0]  store_ff [16];
   logic signed [m4inv_pkg::COF_W-1:0]   cof_ff [16];
   logic [3:0] k_ff, k_in;
   logic [1:0] j_ff, j_in;
   logic [2:0] s_ff, s_in;
   logic signed [m4inv_pkg::ELEM_W-1:0]  opa_ff, opa_in;
   logic signed [m4inv_pkg::PROD_W-1:0]  prod_ff;
   logic signed [m4inv_pkg::MINOR_W-1:0] minor_ff, minor_in;
   logic signed [m4inv_pkg::DET_W-1:0]   acc_ff, acc_in;
   logic                                 det_zero_ff;
   logic                                 dneg_ff;
   logic [m4inv_pkg::DET_W-1:0]          dmag_ff;
   logic                                 cneg_ff;
   logic [m4inv_pkg::NUM_W-1:0]          num_ff;
   logic [m4inv_pkg::REM_W-1:0]          rem_ff;
   logic [m4inv_pkg::QUO_W-1:0]          q_ff;
   logic                                 ovf_ff;
   logic [m4inv_pkg::CNT_W-1:0]          div_cnt_ff;
   logic                                 rsp_valid_ff;
   m4inv_pkg::rsp_type                   rsp_data_ff;

   // Combinational helpers.
   logic                                 req_accept;
   logic                                 rsp_free;
   logic [3:0]                           rd_addr;
   logic signed [m4inv_pkg::ELEM_W-1:0]  rd_elem;
   logic [3:0]                           cof_addr;
   logic signed [m4inv_pkg::COF_W-1:0]   cof_rd;
   logic signed [m4inv_pkg::ELEM_W-1:0]  mul_a;
   logic signed [m4inv_pkg::MULB_W-1:0]  mul_b;
   logic signed [m4inv_pkg::PROD_W-1:0]  mul_p;
   logic signed [m4inv_pkg::DET_W-1:0]   prod_ext;
   logic [1:0]                           row0, row1, row2;
   logic [1:0]                           ca, cb;
   logic                                 term_neg;
   logic [m4inv_pkg::COF_W-1:0]          cof_mag;
   logic [m4inv_pkg::REM_W-1:0]          rem_sh;
   logic [m4inv_pkg::REM_W-1:0]          dmag_ext;
   logic                                 quo_bit;
   logic [m4inv_pkg::VALUE_W-1:0]        quo_ext;
   logic [m4inv_pkg::VALUE_W-1:0]        out_value;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != m4inv_pkg::ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Row and column selection of the 3x3 minor for cofactor k.
   assign row0     = m4inv_pkg::skip_index(2'd0, k_ff[3:2]);
   assign row1     = m4inv_pkg::skip_index(2'd1, k_ff[3:2]);
   assign row2     = m4inv_pkg::skip_index(2'd2, k_ff[3:2]);
   assign ca       = (j_ff == 2'd0) ? 2'd1 : 2'd0;
   assign cb       = (j_ff == 2'd2) ? 2'd1 : 2'd2;
   assign term_neg = j_ff[0] ^ k_ff[2] ^ k_ff[0];

   assign rd_elem = store_ff[rd_addr];
   assign cof_rd  = cof_ff[cof_addr];
   assign mul_p   = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         m4inv_pkg::ST_IDLE: begin
            if (req_accept && req_data.position == m4inv_pkg::LAST_POS) begin
               state_in = m4inv_pkg::ST_COF;
            end
         end
         m4inv_pkg::ST_COF: begin
            if (s_ff == 3'd5 && j_ff == 2'd2) begin
               state_in = m4inv_pkg::ST_COF_END;
            end
         end
         m4inv_pkg::ST_COF_END: begin
            state_in = (k_ff == 4'd15) ? m4inv_pkg::ST_DET : m4inv_pkg::ST_COF;
         end
         m4inv_pkg::ST_DET: begin
            if (s_ff[0] && k_ff[1:0] == 2'd3) begin
               state_in = m4inv_pkg::ST_DET_END;
            end
         end
         m4inv_pkg::ST_DET_END: begin
            state_in = m4inv_pkg::ST_DET_ABS;
         end
         m4inv_pkg::ST_DET_ABS: begin
            state_in = (acc_ff == '0) ? m4inv_pkg::ST_OUT : m4inv_pkg::ST_DIV_LD;
         end
         m4inv_pkg::ST_DIV_LD: begin
            state_in = m4inv_pkg::ST_DIV;
         end
         m4inv_pkg::ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = m4inv_pkg::ST_OUT;
            end
         end
         m4inv_pkg::ST_OUT: begin
            if (rsp_free) begin
               if (k_ff == 4'd15) begin
                  state_in = m4inv_pkg::ST_IDLE;
               end else if (det_zero_ff) begin
                  state_in = m4inv_pkg::ST_OUT;
               end else begin
                  state_in = m4inv_pkg::ST_DIV_LD;
               end
            end
         end
         default: state_in = m4inv_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: counters, read addresses, multiplier operands and actions.
   always_comb begin
      k_in     = k_ff;
      j_in     = j_ff;
      s_in     = s_ff;
      opa_in   = opa_ff;
      act_in   = m4inv_pkg::ACT_NONE;
      rd_addr  = k_ff;
      cof_addr = {k_ff[1:0], k_ff[3:2]};
      mul_a    = opa_ff;
      mul_b    = m4inv_pkg::MULB_W'(rd_elem);
      case (state_ff)
         m4inv_pkg::ST_IDLE: begin
            k_in = 4'd0;
            j_in = 2'd0;
            s_in = 3'd0;
         end
         m4inv_pkg::ST_COF: begin
            case (s_ff)
               3'd0: begin
                  rd_addr = {row1, m4inv_pkg::skip_index(ca, k_ff[1:0])};
                  opa_in  = rd_elem;
               end
               3'd1: begin
                  rd_addr = {row2, m4inv_pkg::skip_index(cb, k_ff[1:0])};
                  act_in  = m4inv_pkg::ACT_MSET;
               end
               3'd2: begin
                  rd_addr = {row1, m4inv_pkg::skip_index(cb, k_ff[1:0])};
                  opa_in  = rd_elem;
               end
               3'd3: begin
                  rd_addr = {row2, m4inv_pkg::skip_index(ca, k_ff[1:0])};
                  act_in  = m4inv_pkg::ACT_MSUB;
               end
               3'd5: begin
                  rd_addr = {row0, m4inv_pkg::skip_index(j_ff, k_ff[1:0])};
                  mul_a   = rd_elem;
                  mul_b   = m4inv_pkg::MULB_W'(minor_ff);
                  act_in  = term_neg ? m4inv_pkg::ACT_CSUB : m4inv_pkg::ACT_CADD;
               end
               default: begin
               end
            endcase
            if (s_ff == 3'd5) begin
               s_in = 3'd0;
               j_in = (j_ff == 2'd2) ? 2'd0 : j_ff + 2'd1;
            end else begin
               s_in = s_ff + 3'd1;
            end
         end
         m4inv_pkg::ST_COF_END: begin
            k_in = k_ff + 4'd1;
            j_in = 2'd0;
            s_in = 3'd0;
         end
         m4inv_pkg::ST_DET: begin
            rd_addr  = {2'd0, k_ff[1:0]};
            cof_addr = {2'd0, k_ff[1:0]};
            mul_a    = rd_elem;
            if (s_ff[0]) begin
               mul_b  = m4inv_pkg::MULB_W'($signed(cof_rd[m4inv_pkg::COF_W-1:m4inv_pkg::CHUNK_W]));
               act_in = m4inv_pkg::ACT_DHI;
               k_in   = k_ff + 4'd1;
               s_in   = 3'd0;
            end else begin
               mul_b  = m4inv_pkg::MULB_W'($signed({1'b0, cof_rd[m4inv_pkg::CHUNK_W-1:0]}));
               act_in = m4inv_pkg::ACT_DLO;
               s_in   = 3'd1;
            end
         end
         m4inv_pkg::ST_DET_ABS: begin
            k_in = 4'd0;
         end
         m4inv_pkg::ST_OUT: begin
            if (rsp_free) begin
               k_in = k_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Accumulation of the registered product.
   always_comb begin
      prod_ext = m4inv_pkg::DET_W'(prod_ff);
      acc_in   = acc_ff;
      minor_in = minor_ff;
      case (act_ff)
         m4inv_pkg::ACT_MSET: minor_in = m4inv_pkg::MINOR_W'(prod_ff);
         m4inv_pkg::ACT_MSUB: minor_in = minor_ff - m4inv_pkg::MINOR_W'(prod_ff);
         m4inv_pkg::ACT_CADD: acc_in   = acc_ff + prod_ext;
         m4inv_pkg::ACT_CSUB: acc_in   = acc_ff - prod_ext;
         m4inv_pkg::ACT_DLO:  acc_in   = acc_ff + prod_ext;
         m4inv_pkg::ACT_DHI:  acc_in   = acc_ff + (prod_ext <<< m4inv_pkg::CHUNK_W);
         default: begin
         end
      endcase
   end

   // Division step and result formatting.
   always_comb begin
      cof_mag  = cof_rd[m4inv_pkg::COF_W-1] ? m4inv_pkg::COF_W'(-cof_rd)
                                            : m4inv_pkg::COF_W'(cof_rd);
      rem_sh   = {rem_ff[m4inv_pkg::REM_W-2:0], num_ff[m4inv_pkg::NUM_W-1]};
      dmag_ext = {1'b0, dmag_ff};
      quo_bit  = (rem_sh >= dmag_ext);
      quo_ext  = {1'b0, q_ff};
      if (det_zero_ff) begin
         out_value = m4inv_pkg::VALUE_W'(rd_elem) <<< m4inv_pkg::SING_SHIFT;
      end else if (cneg_ff != dneg_ff) begin
         out_value = ovf_ff ? m4inv_pkg::SAT_NEG : -quo_ext;
      end else begin
         out_value = ovf_ff ? m4inv_pkg::SAT_POS : quo_ext;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= m4inv_pkg::ST_IDLE;
         act_ff       <= m4inv_pkg::ACT_NONE;
         k_ff         <= 4'd0;
         j_ff         <= 2'd0;
         s_ff         <= 3'd0;
         rsp_valid_ff <= 1'b0;
         det_zero_ff  <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         s_ff     <= s_in;
         if (req_accept) begin
            store_ff[req_data.position] <= req_data.element;
         end
         if (state_ff == m4inv_pkg::ST_DET_ABS) begin
            det_zero_ff <= (acc_ff == '0);
         end
         if (state_ff == m4inv_pkg::ST_OUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      opa_ff   <= opa_in;
      prod_ff  <= mul_p;
      minor_ff <= minor_in;
      if (state_ff == m4inv_pkg::ST_IDLE) begin
         acc_ff <= '0;
      end else if (state_ff == m4inv_pkg::ST_COF_END) begin
         cof_ff[k_ff] <= m4inv_pkg::COF_W'(acc_in);
         acc_ff       <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (state_ff == m4inv_pkg::ST_DET_ABS) begin
         dneg_ff <= acc_ff[m4inv_pkg::DET_W-1];
         dmag_ff <= acc_ff[m4inv_pkg::DET_W-1] ? m4inv_pkg::DET_W'(-acc_ff)
                                               : m4inv_pkg::DET_W'(acc_ff);
      end
      if (state_ff == m4inv_pkg::ST_DIV_LD) begin
         cneg_ff    <= cof_rd[m4inv_pkg::COF_W-1];
         num_ff     <= {cof_mag, {m4inv_pkg::FRAC_SHIFT{1'b0}}};
         rem_ff     <= '0;
         q_ff       <= '0;
         ovf_ff     <= 1'b0;
         div_cnt_ff <= m4inv_pkg::CNT_W'(m4inv_pkg::NUM_W - 1);
      end else if (state_ff == m4inv_pkg::ST_DIV) begin
         rem_ff     <= quo_bit ? rem_sh - dmag_ext : rem_sh;
         num_ff     <= num_ff << 1;
         q_ff       <= {q_ff[m4inv_pkg::QUO_W-2:0], quo_bit};
         ovf_ff     <= ovf_ff | q_ff[m4inv_pkg::QUO_W-1];
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
      if (state_ff == m4inv_pkg::ST_OUT && rsp_free) begin
         rsp_data_ff.value        <= out_value;
         rsp_data_ff.out_position <= k_ff;
         rsp_data_ff.singular     <= det_zero_ff;
         rsp_data_ff.last         <= (k_ff == m4inv_pkg::LAST_POS);
      end
   end

`ifndef ASSERT_OFF
   // A closing element starts the cofactor sweep in the next cycle.
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.position == m4inv_pkg::LAST_POS)
         |=> (state_ff == m4inv_pkg::ST_COF))
      else $error("run did not start after the closing element");

   // A result issued from the output state appears on the port.
   a_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == m4inv_pkg::ST_OUT && rsp_free) |=> rsp_valid_ff)
      else $error("issued result not presented");

   // The divider never runs against a zero determinant.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == m4inv_pkg::ST_DIV) |-> (dmag_ff != '0))
      else $error("division by a zero determinant");

   // A singular result is a Q8.8 element widened, so its low byte is clear.
   a_singular_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.singular) |-> (rsp_data_ff.value[7:0] == 8'd0))
      else $error("singular result carries fraction bits");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverse block.
module tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   m4inv_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   m4inv_pkg::rsp_type rsp_data;

   matrix4_inverse_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor state: the element store as the block holds it.
   logic signed [15:0] elem_store [16];
   m4inv_pkg::rsp_type inverse_queue [$];
   int                 error_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   logic               hold_req = 1'b0;
   logic               hold_seen = 1'b0;
   int                 hold_cycles = 0;
   longint             cycle_count = 0;

   // Signed cofactor of entry (r,c) from the stored elements.
   function automatic longint cofactor_of(int r, int c);
      int     rows[3], cols[3];
      int     n, m, k;
      longint a[3][3], d;
      n = 0;
      m = 0;
      for (k = 0; k < 4; k++) begin
         if (k != r) begin
            rows[n] = k;
            n++;
         end
         if (k != c) begin
            cols[m] = k;
            m++;
         end
      end
      for (k = 0; k < 9; k++) a[k/3][k%3] = elem_store[rows[k/3]*4 + cols[k%3]];
      d = a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
        - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
        + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
      return ((r + c) & 1) ? -d : d;
   endfunction

   // Update the store and, on the last position, queue the sixteen inverse elements.
   task automatic predict_inverse(m4inv_pkg::req_type item);
      longint             cof [4][4];
      logic signed [95:0] det, dmag, num, quo;
      m4inv_pkg::rsp_type res;
      int                 k;
      elem_store[item.position] = item.element;
      if (item.position != m4inv_pkg::LAST_POS) return;
      det = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) cof[r][c] = cofactor_of(r, c);
      for (int c = 0; c < 4; c++)
         det += 96'(signed'(elem_store[c])) * 96'(signed'(cof[0][c]));
      dmag = det < 0 ? -det : det;
      for (k = 0; k < 16; k++) begin
         res.out_position = k[3:0];
         res.last = (k == 15);
         res.singular = (det == 0);
         if (det == 0) begin
            res.value = 32'(signed'(elem_store[k])) <<< m4inv_pkg::SING_SHIFT;
         end else begin
            num = 96'(signed'(cof[k & 3][k >> 2]));
            quo = ((num < 0 ? -num : num) <<< m4inv_pkg::FRAC_SHIFT) / dmag;
            if ((num < 0) != (det < 0)) begin
               res.value = (quo >= 96'sh80000000) ? m4inv_pkg::SAT_NEG : 32'(-quo);
            end else begin
               res.value = (quo > 96'sh7FFFFFFF) ? m4inv_pkg::SAT_POS : 32'(quo);
            end
         end
         inverse_queue.push_back(res);
      end
   endtask

   // Offer one transaction and wait until it is taken.
   task automatic send_element(logic signed [15:0] e, int p);
      m4inv_pkg::req_type item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      item.element = e;
      item.position = p[3:0];
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_inverse(item);
      @(negedge clock);
   endtask

   task automatic send_matrix(logic signed [15:0] m [16]);
      for (int k = 0; k < 16; k++) send_element(m[k], k);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (inverse_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Receiver back-pressure: random stalls, or one long hold-off on request.
   always @(negedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker: compares each accepted transaction with the oldest prediction.
   always @(posedge clock) begin
      m4inv_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (inverse_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = inverse_queue.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
               error_count++;
            end
         end
      end
      if (cycle_count > 2000000) begin
         $display("** matrix4_inverse_top: FAILED **");
         $finish;
      end
   end

   task automatic test_directed();
      logic signed [15:0] m [16];
      // Zero store straight after reset: singular.
      send_element('0, 15);
      // Identity matrix.
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 16'sh0100 : 16'sh0;
      send_matrix(m);
      // Extreme diagonal values.
      for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 16'sh8000 : 16'sh0;
      send_matrix(m);
      // Only position 15 rewritten: recompute with old elements.
      send_element(16'sh7FFF, 15);
      // Full-scale singular matrix with extremes.
      for (int k = 0; k < 16; k++) m[k] = (k < 8) ? 16'sh7FFF : 16'sh8000;
      send_matrix(m);
      wait_drained();
   endtask

   task automatic test_random(int mats);
      logic signed [15:0] m [16];
      int                 mode;
      for (int i = 0; i < mats; i++) begin
         mode = $urandom_range(9);
         for (int k = 0; k < 16; k++) begin
            if (mode < 4) m[k] = 16'($urandom);
            else if (mode < 8) m[k] = 16'(int'($urandom_range(511)) - 256);
            else m[k] = (k % 5 == 0) ? 16'($urandom_range(3) + 1) : 16'sh0;
         end
         // Occasionally make two rows equal so the matrix is singular.
         if (mode == 9) for (int k = 0; k < 4; k++) m[4 + k] = m[k];
         if ($urandom_range(7) == 0) begin
            // Out-of-order and repeated writes.
            for (int k = 0; k < 4; k++) send_element(16'($urandom), int'($urandom_range(14)));
         end
         send_matrix(m);
      end
      wait_drained();
   endtask

   // Long receiver hold-off while further transactions are offered.
   task automatic test_hold_off();
      logic signed [15:0] m [16];
      hold_req = 1'b1;
      for (int k = 0; k < 16; k++) m[k] = 16'(int'($urandom_range(1023)) - 512);
      send_matrix(m);
      for (int k = 0; k < 4; k++) send_element(16'(int'($urandom_range(1023)) - 512), k);
      wait_drained();
   endtask

   initial begin
      for (int k = 0; k < 16; k++) elem_store[k] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 6;
      recv_idle_pct = 87;
      test_directed();
      test_random(1);
      send_idle_pct = 87;
      recv_idle_pct = 6;
      test_random(1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_hold_off();
      if (error_count == 0) begin
         $display("** matrix4_inverse_top: PASSED **");
      end else begin
         $display("** matrix4_inverse_top: FAILED **");
      end
      $finish;
   end
endmodule
